[rtl/core/avp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avp_pkg
// Shared constants, register codes and types for the vector add / ReLU /
// average pooling block.
// ----------------------------------------------------------------------------
package avp_pkg;

   localparam int WORD_WIDTH      = 32;
   localparam int MAX_SIDE        = 256;
   localparam int MAX_STRIDE_LOG2 = 3;

   // accumulator holds a full window of 4^MAX_STRIDE_LOG2 samples
   localparam int ACC_WIDTH  = WORD_WIDTH + 2 * MAX_STRIDE_LOG2;
   localparam int ADDR_WIDTH = $clog2(MAX_SIDE);
   localparam int SIDE_WIDTH = $clog2(MAX_SIDE + 1);
   localparam int ROW_WIDTH  = $clog2(MAX_SIDE);
   localparam int SLE_WIDTH  = $clog2(MAX_STRIDE_LOG2 + 1);

   localparam int LEN_WIDTH      = 16;
   localparam int SL_WIDTH       = 2;
   localparam int CHN_WIDTH      = 13;
   localparam int CH_IDX_WIDTH   = 12;
   localparam int MAX_CHANNELS   = 4096;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_OPERATION     = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RELU_ENABLE   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LENGTH        = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_STRIDE_LOG2   = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CHANNEL_COUNT = 3'd4;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_POOL = 1'b1;

   // per-item command from the sequencer into the datapath
   typedef struct packed {
      logic                  pool;
      logic                  relu;
      logic                  touch;
      logic                  emit;
      logic                  last;
      logic [ADDR_WIDTH-1:0] addr;
      logic [SLE_WIDTH-1:0]  sl;
   } item_cmd_type;

endpackage

[rtl/core/avp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avp channel interfaces
// Valid/ready channels for operand beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface avp_req_if
   import avp_pkg::*;
   ;
   logic                         valid;
   logic                         ready;
   logic signed [WORD_WIDTH-1:0] operand_a;
   logic signed [WORD_WIDTH-1:0] operand_b;

   modport source (output valid, output operand_a, output operand_b, input ready);
   modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface avp_rsp_if
   import avp_pkg::*;
   ;
   logic                         valid;
   logic                         ready;
   logic signed [WORD_WIDTH-1:0] result;
   logic                         final_result;

   modport source (output valid, output result, output final_result, input ready);
   modport sink   (input valid, input result, input final_result, output ready);
endinterface

interface avp_csr_if
   import avp_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic [CSR_IDX_WIDTH-1:0]  index;
   logic [CSR_DATA_WIDTH-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/avp_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avp_seq
// Configuration registers and the column / row / channel counters. Decodes
// the current position into a command for the next accepted beat.
// ----------------------------------------------------------------------------
module avp_seq
   import avp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   avp_csr_if.sink      csr,
   input  logic         advance,
   output item_cmd_type cmd,
   output logic         clear
);

   logic                    op_ff, op_in;
   logic                    relu_ff, relu_in;
   logic [LEN_WIDTH-1:0]    len_ff, len_in;
   logic [SL_WIDTH-1:0]     sl_ff, sl_in;
   logic [CHN_WIDTH-1:0]    chn_ff, chn_in;
   logic [LEN_WIDTH-1:0]    col_ff, col_in;
   logic [ROW_WIDTH-1:0]    row_ff, row_in;
   logic [CH_IDX_WIDTH-1:0] ch_ff, ch_in;

   logic                    wr_hit;
   logic [SLE_WIDTH-1:0]    sle;
   logic [SIDE_WIDTH-1:0]   side;
   logic [SIDE_WIDTH-1:0]   full;
   logic [LEN_WIDTH-1:0]    mask;
   logic [SIDE_WIDTH-1:0]   row_next;
   logic [LEN_WIDTH:0]      col_next_wide;
   logic [LEN_WIDTH-1:0]    add_next;
   logic                    add_fin;
   logic [CHN_WIDTH-1:0]    chn_eff;
   logic [CHN_WIDTH-1:0]    ch_next;
   logic                    in_full;
   logic                    corner;
   logic                    pool_last;

   assign csr.ready = 1'b1;

   always_comb begin
      op_in   = op_ff;
      relu_in = relu_ff;
      len_in  = len_ff;
      sl_in   = sl_ff;
      chn_in  = chn_ff;
      wr_hit  = 1'b0;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_OPERATION: begin
               op_in  = csr.data[0];
               wr_hit = 1'b1;
            end
            CSR_RELU_ENABLE: begin
               relu_in = csr.data[0];
               wr_hit  = 1'b1;
            end
            CSR_LENGTH: begin
               len_in = csr.data[LEN_WIDTH-1:0];
               wr_hit = 1'b1;
            end
            CSR_STRIDE_LOG2: begin
               sl_in  = csr.data[SL_WIDTH-1:0];
               wr_hit = 1'b1;
            end
            CSR_CHANNEL_COUNT: begin
               chn_in = csr.data[CHN_WIDTH-1:0];
               wr_hit = 1'b1;
            end
            default: wr_hit = 1'b0;
         endcase
      end
   end

   assign clear = wr_hit;

   // position decode
   always_comb begin
      if (int'(sl_ff) > MAX_STRIDE_LOG2) sle = SLE_WIDTH'(MAX_STRIDE_LOG2);
      else                               sle = SLE_WIDTH'(sl_ff);

      if (len_ff > LEN_WIDTH'(MAX_SIDE)) side = SIDE_WIDTH'(MAX_SIDE);
      else                               side = SIDE_WIDTH'(len_ff);

      full = (side >> sle) << sle;
      mask = (LEN_WIDTH'(1) << sle) - LEN_WIDTH'(1);

      if (chn_ff == '0)                              chn_eff = CHN_WIDTH'(1);
      else if (chn_ff > CHN_WIDTH'(MAX_CHANNELS))    chn_eff = CHN_WIDTH'(MAX_CHANNELS);
      else                                           chn_eff = chn_ff;

      row_next      = SIDE_WIDTH'(row_ff) + SIDE_WIDTH'(1);
      col_next_wide = {1'b0, col_ff} + (LEN_WIDTH+1)'(1);
      ch_next       = {1'b0, ch_ff} + CHN_WIDTH'(1);
      add_next      = col_ff + LEN_WIDTH'(1);
      add_fin       = (add_next == len_ff);

      in_full   = (col_ff < LEN_WIDTH'(full)) && (SIDE_WIDTH'(row_ff) < full);
      corner    = ((col_ff & mask) == mask) && ((LEN_WIDTH'(row_ff) & mask) == mask);
      pool_last = (col_next_wide == (LEN_WIDTH+1)'(full)) && (row_next == full)
                  && (ch_next == chn_eff);

      cmd.pool  = op_ff;
      cmd.relu  = relu_ff;
      cmd.touch = in_full;
      cmd.emit  = in_full && corner;
      cmd.last  = (op_ff == OP_POOL) ? pool_last : add_fin;
      cmd.addr  = ADDR_WIDTH'(col_ff >> sle);
      cmd.sl    = sle;
   end

   // counter advance
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      ch_in  = ch_ff;
      if (wr_hit) begin
         col_in = '0;
         row_in = '0;
         ch_in  = '0;
      end else if (advance) begin
         if (op_ff == OP_ADD) begin
            col_in = add_fin ? '0 : add_next;
         end else if (col_next_wide >= (LEN_WIDTH+1)'(side)) begin
            col_in = '0;
            if (row_next >= side) begin
               row_in = '0;
               ch_in  = (ch_next >= chn_eff) ? '0 : ch_next[CH_IDX_WIDTH-1:0];
            end else begin
               row_in = row_next[ROW_WIDTH-1:0];
            end
         end else begin
            col_in = col_next_wide[LEN_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff   <= OP_ADD;
         relu_ff <= 1'b0;
         len_ff  <= LEN_WIDTH'(1);
         sl_ff   <= SL_WIDTH'(1);
         chn_ff  <= CHN_WIDTH'(1);
         col_ff  <= '0;
         row_ff  <= '0;
         ch_ff   <= '0;
      end else begin
         op_ff   <= op_in;
         relu_ff <= relu_in;
         len_ff  <= len_in;
         sl_ff   <= sl_in;
         chn_ff  <= chn_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         ch_ff   <= ch_in;
      end
   end

endmodule

[rtl/core/avp_line_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avp_line_store
// One partial window sum per window column. Synchronous read with
// registered data; per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module avp_line_store
   import avp_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic                        rd_en,
   input  logic [ADDR_WIDTH-1:0]       rd_addr,
   output logic signed [ACC_WIDTH-1:0] rd_data,
   input  logic                        wr_en,
   input  logic [ADDR_WIDTH-1:0]       wr_addr,
   input  logic signed [ACC_WIDTH-1:0] wr_data
);

   logic signed [ACC_WIDTH-1:0] mem [MAX_SIDE];
   logic [MAX_SIDE-1:0]         vld_ff;
   logic signed [ACC_WIDTH-1:0] mem_q_ff;
   logic                        vld_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff   <= '0;
         vld_q_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            vld_q_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = vld_q_ff ? mem_q_ff : '0;

endmodule

[rtl/core/avp_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avp_pipe
// Accept stage, read-modify-write stage with write bypass, and the result
// register. Add mode goes straight through; pooling accumulates in the
// line store and emits on the bottom-right sample of each window.
// ----------------------------------------------------------------------------
module avp_pipe
   import avp_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   avp_req_if.sink                     req,
   avp_rsp_if.source                   rsp,
   input  item_cmd_type                cmd,
   output logic                        accept,
   output logic                        rd_en,
   output logic [ADDR_WIDTH-1:0]       rd_addr,
   input  logic signed [ACC_WIDTH-1:0] rd_data,
   output logic                        wr_en,
   output logic [ADDR_WIDTH-1:0]       wr_addr,
   output logic signed [ACC_WIDTH-1:0] wr_data
);

   logic                         s1_v_ff, s1_v_in;
   item_cmd_type                 s1_cmd_ff;
   logic signed [WORD_WIDTH-1:0] s1_a_ff;
   logic signed [WORD_WIDTH-1:0] s1_b_ff;

   logic                         byp_v_ff;
   logic [ADDR_WIDTH-1:0]        byp_addr_ff;
   logic signed [ACC_WIDTH-1:0]  byp_data_ff;

   logic                         out_v_ff, out_v_in;
   logic signed [WORD_WIDTH-1:0] out_res_ff, out_res_in;
   logic                         out_fin_ff, out_fin_in;

   logic                         slot_free;
   logic                         s1_fire;
   logic                         produce;
   logic signed [ACC_WIDTH-1:0]  base;
   logic signed [ACC_WIDTH-1:0]  acc;
   logic signed [ACC_WIDTH-1:0]  avg;
   logic signed [WORD_WIDTH-1:0] add_sum;

   assign slot_free = !out_v_ff || rsp.ready;
   assign s1_fire   = s1_v_ff && slot_free;
   assign req.ready = !s1_v_ff || s1_fire;
   assign accept    = req.valid && req.ready;

   assign rd_en   = accept;
   assign rd_addr = cmd.addr;

   always_comb begin
      // newest write to this entry wins over the registered read
      if (byp_v_ff && (byp_addr_ff == s1_cmd_ff.addr)) base = byp_data_ff;
      else                                            base = rd_data;

      acc = base + {{(ACC_WIDTH-WORD_WIDTH){s1_a_ff[WORD_WIDTH-1]}}, s1_a_ff};
      avg = acc >>> {s1_cmd_ff.sl, 1'b0};

      add_sum = s1_a_ff + s1_b_ff;
      if (s1_cmd_ff.relu && add_sum[WORD_WIDTH-1]) add_sum = '0;

      produce = (s1_cmd_ff.pool == OP_ADD) || s1_cmd_ff.emit;

      wr_en   = s1_fire && (s1_cmd_ff.pool == OP_POOL) && s1_cmd_ff.touch;
      wr_addr = s1_cmd_ff.addr;
      wr_data = s1_cmd_ff.emit ? '0 : acc;
   end

   always_comb begin
      s1_v_in    = s1_v_ff;
      out_v_in   = out_v_ff;
      out_res_in = out_res_ff;
      out_fin_in = out_fin_ff;
      if (accept)       s1_v_in = 1'b1;
      else if (s1_fire) s1_v_in = 1'b0;
      if (s1_fire && produce) begin
         out_v_in   = 1'b1;
         out_res_in = (s1_cmd_ff.pool == OP_POOL) ? avg[WORD_WIDTH-1:0] : add_sum;
         out_fin_in = s1_cmd_ff.last;
      end else if (rsp.ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         byp_v_ff <= 1'b0;
      end else if (wr_en) begin
         byp_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff <= cmd;
         s1_a_ff   <= req.operand_a;
         s1_b_ff   <= req.operand_b;
      end
      if (wr_en) begin
         byp_addr_ff <= wr_addr;
         byp_data_ff <= wr_data;
      end
      out_res_ff <= out_res_in;
      out_fin_ff <= out_fin_in;
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.result       = out_res_ff;
   assign rsp.final_result = out_fin_ff;

endmodule

[rtl/core/vector_add_relu_avg_pool_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_add_relu_avg_pool_top
// Elementwise add with optional ReLU, or square average pooling over a
// column line store.
//
//   channel   dir  payload                        beat on
//   req_bus   in   operand_a, operand_b           valid & ready
//   rsp_bus   out  result, final_result           valid & ready
//   csr_bus   in   index, data                    valid & ready (always ready)
//
// One beat per cycle sustained while results are taken; the line store is
// read at the edge that accepts a beat, then the add and write back go
// into the result register. Same-entry read-after-write is covered by a
// one-entry bypass.
// Reset and a mapped register write clear the counters and the line-store
// valid bits at once. A stalled result blocks at most one further beat.
// ----------------------------------------------------------------------------
module vector_add_relu_avg_pool_top
   import avp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   avp_req_if.sink   req_bus,
   avp_rsp_if.source rsp_bus,
   avp_csr_if.sink   csr_bus
);

   item_cmd_type                cmd;
   logic                        clear;
   logic                        accept;
   logic                        rd_en;
   logic [ADDR_WIDTH-1:0]       rd_addr;
   logic signed [ACC_WIDTH-1:0] rd_data;
   logic                        wr_en;
   logic [ADDR_WIDTH-1:0]       wr_addr;
   logic signed [ACC_WIDTH-1:0] wr_data;

   avp_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr_bus),
      .advance (accept),
      .cmd     (cmd),
      .clear   (clear)
   );

   avp_line_store u_line_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   avp_pipe u_pipe (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .cmd     (cmd),
      .accept  (accept),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule

[rtl/core/avp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avp_checker
// Port-level checks on the result channel and the backpressure path.
// ----------------------------------------------------------------------------
module avp_checker
   import avp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [WORD_WIDTH-1:0] rsp_result,
   input logic                  rsp_final,
   input logic                  csr_ready
);

   // input stalls only behind a stalled result
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req stalled without a stalled result");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port not ready");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_result) && $stable(rsp_final)))
      else $error("result payload changed while stalled");

endmodule

bind vector_add_relu_avg_pool_top avp_checker u_avp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_result (rsp_bus.result),
   .rsp_final  (rsp_bus.final_result),
   .csr_ready  (csr_bus.ready)
);

[dv/vector_add_relu_avg_pool_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_add_relu_avg_pool_top_tb
// Self-checking bench for the add / ReLU / average pooling block. A local
// model of the datapath predicts every result beat from each accepted operand
// beat. The predictions are queued and compared field by field with the
// result channel. Directed tests cover the word extremes, ReLU, window
// averaging, odd feature sizes and the register clamps. A short random phase
// follows, with idle bursts and back-pressure on both channels.
// ----------------------------------------------------------------------------
module vector_add_relu_avg_pool_top_tb;
   import avp_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned RANDOM_ITEMS  = 40;
   localparam longint      TIMEOUT_NS    = 2_000_000;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_UNMAPPED = 3'd7;

   localparam logic signed [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic signed [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] result;
      logic                         final_result;
   } avp_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   avp_req_if req_bus ();
   avp_rsp_if rsp_bus ();
   avp_csr_if csr_bus ();

   vector_add_relu_avg_pool_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // configuration and job state of the datapath model
   logic                 cfg_operation;
   logic                 cfg_relu;
   logic [LEN_WIDTH-1:0] cfg_length;
   logic [SL_WIDTH-1:0]  cfg_stride_log2;
   logic [CHN_WIDTH-1:0] cfg_channels;
   logic signed [63:0]   line_sums [MAX_SIDE];
   int unsigned          col_idx;
   int unsigned          row_idx;
   int unsigned          chan_idx;

   avp_beat_type pending_results [$];
   int unsigned  items_sent  = 0;
   int unsigned  error_count = 0;
   bit           req_gaps    = 1'b0;
   bit           rsp_gaps    = 1'b0;
   int unsigned  sink_hold   = 0;
   int unsigned  sink_gap    = 0;

   function automatic void clear_job_state();
      foreach (line_sums[i]) line_sums[i] = '0;
      col_idx  = 0;
      row_idx  = 0;
      chan_idx = 0;
   endfunction

   // Advance the model by one operand beat; returns 1 when a result beat is due.
   function automatic bit compute_result(input logic signed [WORD_WIDTH-1:0] a,
                                         input logic signed [WORD_WIDTH-1:0] b,
                                         output avp_beat_type beat);
      logic signed [WORD_WIDTH-1:0] sum;
      logic [LEN_WIDTH-1:0]         next_count;
      logic signed [63:0]           avg;
      int unsigned                  side, chn, stride, full, c, r, w;
      bit                           emit;
      beat = '0;
      emit = 1'b0;
      if (cfg_operation == OP_ADD) begin
         sum               = a + b;
         next_count        = LEN_WIDTH'(col_idx + 1);
         beat.final_result = (next_count == cfg_length);
         if (cfg_relu && sum[WORD_WIDTH-1])
            sum = '0;
         beat.result = sum;
         col_idx     = beat.final_result ? 0 : next_count;
         return 1'b1;
      end
      side = (cfg_length > MAX_SIDE) ? MAX_SIDE : cfg_length;
      chn  = (cfg_channels == 0) ? 1 :
             (cfg_channels > MAX_CHANNELS) ? MAX_CHANNELS : cfg_channels;
      stride = 1 << cfg_stride_log2;
      full   = (side >> cfg_stride_log2) << cfg_stride_log2;
      c      = col_idx;
      r      = row_idx;
      if (c < full && r < full) begin
         w            = c >> cfg_stride_log2;
         line_sums[w] = line_sums[w] + a;
         // bottom-right sample closes the window
         if ((r & (stride - 1)) == stride - 1 && (c & (stride - 1)) == stride - 1) begin
            avg               = line_sums[w] >>> (2 * cfg_stride_log2);
            line_sums[w]      = '0;
            beat.result       = avg[WORD_WIDTH-1:0];
            beat.final_result = (r == full - 1 && c == full - 1 && chan_idx + 1 == chn);
            emit              = 1'b1;
         end
      end
      if (c + 1 >= side) begin
         col_idx = 0;
         if (r + 1 >= side) begin
            row_idx  = 0;
            chan_idx = (chan_idx + 1 >= chn) ? 0 : chan_idx + 1;
         end else begin
            row_idx = r + 1;
         end
      end else begin
         col_idx = c + 1;
      end
      return emit;
   endfunction

   function automatic logic signed [WORD_WIDTH-1:0] pick_word();
      case ($urandom_range(0, 11))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // result channel ready: random stalls plus long hold-offs requested by tests
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         sink_gap      <= 0;
      end else if (sink_hold != 0) begin
         rsp_bus.ready <= 1'b0;
         sink_hold     <= sink_hold - 1;
      end else if (sink_gap != 0) begin
         rsp_bus.ready <= 1'b0;
         sink_gap      <= sink_gap - 1;
      end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         sink_gap      <= $urandom_range(0, 6);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      avp_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result beat, expected none, actual %0d final %0b",
                     $time, rsp_bus.result, rsp_bus.final_result);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.result !== want.result) begin
               error_count++;
               $display("%0t: result mismatch, expected %0d actual %0d",
                        $time, want.result, rsp_bus.result);
            end
            if (rsp_bus.final_result !== want.final_result) begin
               error_count++;
               $display("%0t: final_result mismatch, expected %0b actual %0b",
                        $time, want.final_result, rsp_bus.final_result);
            end
         end
      end
   end

   // Leave valid high after the beat so back-to-back beats need no extra edge.
   task automatic send_operands(input logic signed [WORD_WIDTH-1:0] a,
                                input logic signed [WORD_WIDTH-1:0] b);
      avp_beat_type beat;
      if (req_gaps && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operand_a <= a;
      req_bus.operand_b <= b;
      do @(posedge clock); while (!req_bus.ready);
      if (compute_result(a, b, beat))
         pending_results.push_back(beat);
      items_sent++;
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Samples that emit nothing may still be in the pipe; let them retire.
   task automatic settle_block();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_WIDTH-1:0]  idx,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      bit mapped;
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
      mapped = 1'b1;
      case (idx)
         CSR_OPERATION:     cfg_operation   = data[0];
         CSR_RELU_ENABLE:   cfg_relu        = data[0];
         CSR_LENGTH:        cfg_length      = data[LEN_WIDTH-1:0];
         CSR_STRIDE_LOG2:   cfg_stride_log2 = data[SL_WIDTH-1:0];
         CSR_CHANNEL_COUNT: cfg_channels    = data[CHN_WIDTH-1:0];
         default:           mapped          = 1'b0;
      endcase
      if (mapped)
         clear_job_state();
   endtask

   task automatic program_job(input logic op, input logic relu,
                              input logic [LEN_WIDTH-1:0] len,
                              input logic [SL_WIDTH-1:0]  sl,
                              input logic [CHN_WIDTH-1:0] chn,
                              input bit noisy);
      logic [CSR_DATA_WIDTH-1:0] fill;
      settle_block();
      // noisy writes set the unused upper data bits
      fill = noisy ? CSR_DATA_WIDTH'($urandom) : '0;
      write_register(CSR_OPERATION,     {fill[CSR_DATA_WIDTH-1:1], op});
      write_register(CSR_RELU_ENABLE,   {fill[CSR_DATA_WIDTH-1:1], relu});
      write_register(CSR_LENGTH,        len);
      write_register(CSR_STRIDE_LOG2,   {fill[CSR_DATA_WIDTH-1:SL_WIDTH], sl});
      write_register(CSR_CHANNEL_COUNT, {fill[CSR_DATA_WIDTH-1:CHN_WIDTH], chn});
   endtask

   task automatic test_add_extremes();
      program_job(OP_ADD, 1'b0, 4, 0, 1, 1'b0);
      send_operands(WORD_MAX, WORD_MAX);
      send_operands(WORD_MIN, WORD_MIN);
      send_operands(WORD_MAX, 1);
      send_operands(WORD_MIN, -1);
      send_operands('0, '0);
      send_operands(-1, 1);
      send_operands(WORD_MAX, WORD_MIN);
      send_operands(WORD_MIN, '0);
      // negative sums clamp to zero, wrapped sums follow the wrapped sign
      program_job(OP_ADD, 1'b1, 3, 0, 1, 1'b0);
      send_operands(WORD_MAX, 1);
      send_operands(-5, 2);
      send_operands(WORD_MIN, WORD_MIN);
      send_operands(-1, 1);
      send_operands(100, 23);
      send_operands(WORD_MIN, -1);
      // zero length never reaches the end of the vector within a short run
      program_job(OP_ADD, 1'b0, 0, 0, 1, 1'b0);
      repeat (3) send_operands(pick_word(), pick_word());
      program_job(OP_ADD, 1'b0, 1, 0, 1, 1'b0);
      send_operands(WORD_MAX, WORD_MAX);
      send_operands('0, -7);
   endtask

   task automatic test_pool_windows();
      program_job(OP_POOL, 1'b0, 2, 1, 4, 1'b0);
      repeat (4) send_operands(WORD_MAX, WORD_MIN);
      repeat (4) send_operands(WORD_MIN, WORD_MAX);
      repeat (2) begin
         send_operands(WORD_MAX, '0);
         send_operands(WORD_MIN, '0);
      end
      // floor of a negative average
      send_operands(-1, '0);
      repeat (3) send_operands('0, '0);
      program_job(OP_POOL, 1'b1, 8, 3, 1, 1'b0);
      repeat (64) send_operands(WORD_MIN, pick_word());
   endtask

   task automatic test_pool_corner_cases();
      // side zero: counters advance, nothing emitted
      program_job(OP_POOL, 1'b0, 0, 1, 1, 1'b0);
      repeat (5) send_operands(pick_word(), pick_word());
      // side smaller than the window
      program_job(OP_POOL, 1'b0, 3, 2, 2, 1'b0);
      repeat (9) send_operands(pick_word(), pick_word());
      // trailing row and column dropped
      program_job(OP_POOL, 1'b0, 5, 1, 1, 1'b0);
      repeat (25) send_operands(pick_word(), pick_word());
      // zero channels act as one: two whole jobs
      program_job(OP_POOL, 1'b0, 2, 1, 0, 1'b0);
      repeat (8) send_operands(pick_word(), pick_word());
      program_job(OP_POOL, 1'b0, 3, 0, 1, 1'b0);
      repeat (9) send_operands(pick_word(), pick_word());
   endtask

   task automatic test_unmapped_index();
      program_job(OP_POOL, 1'b0, 4, 1, 1, 1'b0);
      repeat (4) send_operands(pick_word(), pick_word());
      settle_block();
      // no register behind this index: the job must carry on
      write_register(CSR_UNMAPPED, '1);
      repeat (4) send_operands(pick_word(), pick_word());
   endtask

   task automatic test_backpressure();
      program_job(OP_ADD, 1'b1, 7, 0, 1, 1'b0);
      sink_hold = 80;
      repeat (20) send_operands(pick_word(), pick_word());
      drain_results();
      repeat (6) send_operands(pick_word(), pick_word());
      program_job(OP_POOL, 1'b0, 4, 0, 1, 1'b0);
      sink_hold = 50;
      repeat (16) send_operands(pick_word(), pick_word());
   endtask

   task automatic test_side_clamp();
      // 65535 clamps to 256: the first window closes early in the second row
      program_job(OP_POOL, 1'b0, '1, 1, 1, 1'b0);
      repeat (MAX_SIDE + 4) send_operands(pick_word(), pick_word());
   endtask

   task automatic test_channel_clamp();
      // 8191 channels clamp to 4096: one beat per channel, final stays low
      program_job(OP_POOL, 1'b0, 1, 0, '1, 1'b0);
      repeat (4) send_operands(pick_word(), pick_word());
   endtask

   task automatic test_random_jobs();
      int unsigned          first, done, side, eff_side, sl, chn_eff, count;
      logic [LEN_WIDTH-1:0] len;
      logic [CHN_WIDTH-1:0] chn;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         done     = items_sent - first;
         // idle-free tail
         req_gaps = done + 20 < RANDOM_ITEMS && $urandom_range(0, 3) != 0;
         rsp_gaps = done + 20 < RANDOM_ITEMS && $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 7))
               0:       len = '0;
               1:       len = '1;
               default: len = LEN_WIDTH'($urandom_range(1, 12));
            endcase
            program_job(OP_ADD, 1'($urandom_range(0, 1)), len,
                        SL_WIDTH'($urandom_range(0, 3)),
                        CHN_WIDTH'($urandom_range(0, 8191)), 1'b1);
            if (len == 0 || len > 12)
               count = $urandom_range(1, 20);
            else
               count = len * $urandom_range(1, 3);
            if ($urandom_range(0, 5) == 0)
               count = $urandom_range(1, count);
         end else begin
            sl = $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0)
               side = $urandom_range(0, 3);
            else
               side = $urandom_range(1 << sl, (1 << sl) + 4);
            case ($urandom_range(0, 7))
               0:       chn = '0;
               1:       chn = CHN_WIDTH'(MAX_CHANNELS);
               2:       chn = '1;
               default: chn = CHN_WIDTH'($urandom_range(1, 3));
            endcase
            program_job(OP_POOL, 1'($urandom_range(0, 1)), LEN_WIDTH'(side),
                        SL_WIDTH'(sl), chn, 1'b1);
            eff_side = (side == 0) ? 1 : side;
            // huge channel counts get a partial job only
            chn_eff  = (chn == 0 || chn > 3) ? 1 : chn;
            count    = eff_side * eff_side * chn_eff * (($urandom_range(0, 3) == 0) ? 2 : 1);
            if ($urandom_range(0, 5) == 0)
               count = $urandom_range(1, count);
         end
         // stay within the beat budget of this phase
         if (count > RANDOM_ITEMS - done)
            count = RANDOM_ITEMS - done;
         repeat (count) send_operands(pick_word(), pick_word());
      end
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.operand_a = '0;
      req_bus.operand_b = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      cfg_operation     = OP_ADD;
      cfg_relu          = 1'b0;
      cfg_length        = 1;
      cfg_stride_log2   = 1;
      cfg_channels      = 1;
      clear_job_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      test_add_extremes();
      test_pool_windows();
      test_pool_corner_cases();
      test_unmapped_index();
      test_backpressure();
      test_side_clamp();
      test_channel_clamp();
      test_random_jobs();
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      settle_block();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
